### src/sdz_pkg.sv
// Shared constants for the stick radial deadzone block.
`default_nettype none
package sdz_pkg;
  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF   = 15;
  localparam int unsigned DZ_W            = 15;
  localparam int unsigned OUT_W           = 16;
  localparam int unsigned IN_W            = 16;
  localparam logic [DZ_W-1:0]  DZ_RESET = 15'd3924;
  localparam logic [DZ_W-1:0]  DZ_MAX   = 15'd32766;
  localparam logic [OUT_W-1:0] OUT_MAX  = 16'h7FFF;
endpackage
`default_nettype wire

### src/stick_radial_deadzone.sv
// Top level of the stick radial deadzone block.
// Takes one stick sample per cycle while in_stall is low and returns one result per
// sample, in order. The stages are clamping and squaring, then summing, one square
// root cell per root bit, the rescale multiplies, one divider cell per quotient bit
// and the output register. A stalled output holds the whole row of cells.
`default_nettype none
module stick_radial_deadzone import sdz_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_wen,
  input  wire logic [DZ_W-1:0]         cfg_wdata,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic signed [IN_W-1:0]  stick_x,
  input  wire logic signed [IN_W-1:0]  stick_y,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [OUT_W-1:0]      norm_x,
  output logic signed [OUT_W-1:0]      norm_y,
  output logic                         in_deadzone
);
  localparam int unsigned S   = SAMPLE_BITS;
  localparam int unsigned NW  = 2 * S;
  localparam int unsigned QW  = FRAC_BITS + 1;
  localparam int unsigned SSW = 2 * S;
  localparam int unsigned DSW = 3;
  localparam logic [S-2:0] FS  = {(S-1){1'b1}};
  localparam logic [S-1:0] NEG = {1'b1, {(S-1){1'b0}}};

  logic en;
  logic [DZ_W-1:0] deadzone;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      deadzone <= DZ_RESET;
    end else if (cfg_wen) begin
      deadzone <= (cfg_wdata > DZ_MAX) ? DZ_MAX : cfg_wdata;
    end
  end

  logic signed [S-1:0] cx;
  logic signed [S-1:0] cy;
  always_comb begin
    cx = (stick_x[S-1:0] == NEG) ? -$signed({1'b0, FS}) : $signed(stick_x[S-1:0]);
    cy = (stick_y[S-1:0] == NEG) ? -$signed({1'b0, FS}) : $signed(stick_y[S-1:0]);
  end

  logic                 v1;
  logic signed [S-1:0]  ax1;
  logic signed [S-1:0]  ay1;
  logic signed [NW-1:0] sqx1;
  logic signed [NW-1:0] sqy1;
  logic                 v2;
  logic signed [S-1:0]  ax2;
  logic signed [S-1:0]  ay2;
  logic [NW-1:0]        sum2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax1  <= cx;
      ay1  <= cy;
      sqx1 <= NW'(cx) * NW'(cx);
      sqy1 <= NW'(cy) * NW'(cy);
      ax2  <= ax1;
      ay2  <= ay1;
      sum2 <= unsigned'(sqx1) + unsigned'(sqy1);
    end
  end

  logic           sv   [S+1];
  logic [NW-1:0]  sn   [S+1];
  logic [NW-1:0]  sres [S+1];
  logic [SSW-1:0] sside[S+1];

  assign sv[0]    = v2;
  assign sn[0]    = sum2;
  assign sres[0]  = '0;
  assign sside[0] = {ax2, ay2};

  for (genvar k = 0; k < S; k++) begin : g_sqrt
    sdz_sqrt_cell #(
      .NW(NW), .SW(SSW), .BIT_POS(2 * (S - 1 - k))
    ) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(sv[k]), .in_n(sn[k]), .in_res(sres[k]), .in_side(sside[k]),
      .out_valid(sv[k+1]), .out_n(sn[k+1]), .out_res(sres[k+1]),
      .out_side(sside[k+1])
    );
  end

  logic [S-1:0]        root;
  logic signed [S-1:0] rax;
  logic signed [S-1:0] ray;
  logic [S-2:0]        dz_use;
  logic [S-2:0]        mcl;
  logic [S-2:0]        over;
  logic [S-2:0]        span;
  logic [S-2:0]        magx;
  logic [S-2:0]        magy;
  logic                dzhit;

  always_comb begin
    root   = sres[S][S-1:0];
    rax    = $signed(sside[S][SSW-1:S]);
    ray    = $signed(sside[S][S-1:0]);
    dz_use = (deadzone > DZ_W'(FS - 1'b1)) ? (FS - 1'b1) : deadzone[S-2:0];
    dzhit  = (root <= S'(dz_use));
    mcl    = (root > S'(FS)) ? FS : root[S-2:0];
    over   = mcl - dz_use;
    span   = FS - dz_use;
    magx   = rax[S-1] ? (S-1)'(-rax) : rax[S-2:0];
    magy   = ray[S-1] ? (S-1)'(-ray) : ray[S-2:0];
  end

  logic          v3;
  logic [NW-1:0] den3;
  logic [NW-1:0] px3;
  logic [NW-1:0] py3;
  logic [DSW-1:0] side3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= sv[S];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den3  <= NW'(root) * NW'(span);
      px3   <= NW'(magx) * NW'(over);
      py3   <= NW'(magy) * NW'(over);
      side3 <= {dzhit, rax[S-1], ray[S-1]};
    end
  end

  logic           dv   [QW+1];
  logic [NW-1:0]  dden [QW+1];
  logic [NW-1:0]  drx  [QW+1];
  logic [NW-1:0]  dry  [QW+1];
  logic [QW-1:0]  dqx  [QW+1];
  logic [QW-1:0]  dqy  [QW+1];
  logic [DSW-1:0] dside[QW+1];

  assign dv[0]    = v3;
  assign dden[0]  = den3;
  assign drx[0]   = px3;
  assign dry[0]   = py3;
  assign dqx[0]   = '0;
  assign dqy[0]   = '0;
  assign dside[0] = side3;

  for (genvar k = 0; k < QW; k++) begin : g_div
    sdz_div_cell #(
      .RW(NW), .QW(QW), .SW(DSW), .FIRST(k == 0)
    ) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(dv[k]), .in_den(dden[k]), .in_rx(drx[k]), .in_ry(dry[k]),
      .in_qx(dqx[k]), .in_qy(dqy[k]), .in_side(dside[k]),
      .out_valid(dv[k+1]), .out_den(dden[k+1]), .out_rx(drx[k+1]),
      .out_ry(dry[k+1]), .out_qx(dqx[k+1]), .out_qy(dqy[k+1]),
      .out_side(dside[k+1])
    );
  end

  logic [OUT_W-1:0] satx;
  logic [OUT_W-1:0] saty;
  logic             fhit;
  logic             fsx;
  logic             fsy;

  always_comb begin
    {fhit, fsx, fsy} = dside[QW];
    satx = (41'(dqx[QW]) > 41'(OUT_MAX)) ? OUT_MAX : OUT_W'(dqx[QW]);
    saty = (41'(dqy[QW]) > 41'(OUT_MAX)) ? OUT_MAX : OUT_W'(dqy[QW]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_deadzone <= fhit;
      norm_x      <= fhit ? '0 : (fsx ? -$signed(satx) : $signed(satx));
      norm_y      <= fhit ? '0 : (fsy ? -$signed(saty) : $signed(saty));
    end
  end

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && in_deadzone) |-> (norm_x == '0 && norm_y == '0))
    else $error("deadzone result not zero");
  a_dz_reg: assert property (@(posedge clk) disable iff (rst)
    cfg_wen |=> (deadzone <= DZ_MAX))
    else $error("deadzone register above limit");
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (norm_x != 16'sh8000 && norm_y != 16'sh8000))
    else $error("output outside full scale");
endmodule
`default_nettype wire

### src/sdz_sqrt_cell.sv
// One digit step of the pipelined integer square root.
`default_nettype none
module sdz_sqrt_cell import sdz_pkg::*; #(
  parameter int unsigned NW      = 32,
  parameter int unsigned SW      = 32,
  parameter int unsigned BIT_POS = 0
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [NW-1:0] in_n,
  input  wire logic [NW-1:0] in_res,
  input  wire logic [SW-1:0] in_side,
  output logic               out_valid,
  output logic      [NW-1:0] out_n,
  output logic      [NW-1:0] out_res,
  output logic      [SW-1:0] out_side
);
  localparam logic [NW-1:0] BITV = NW'(1) << BIT_POS;

  logic [NW-1:0] trial;
  logic          ge;
  logic [NW-1:0] n_next;
  logic [NW-1:0] res_next;

  always_comb begin
    trial    = in_res + BITV;
    ge       = (in_n >= trial);
    n_next   = ge ? (in_n - trial) : in_n;
    res_next = ge ? ((in_res >> 1) + BITV) : (in_res >> 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_n    <= n_next;
      out_res  <= res_next;
      out_side <= in_side;
    end
  end
endmodule
`default_nettype wire

### src/sdz_div_cell.sv
// One quotient bit step for both axes of the restoring divider.
`default_nettype none
module sdz_div_cell import sdz_pkg::*; #(
  parameter int unsigned RW    = 32,
  parameter int unsigned QW    = 16,
  parameter int unsigned SW    = 3,
  parameter bit          FIRST = 1'b0
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [RW-1:0] in_den,
  input  wire logic [RW-1:0] in_rx,
  input  wire logic [RW-1:0] in_ry,
  input  wire logic [QW-1:0] in_qx,
  input  wire logic [QW-1:0] in_qy,
  input  wire logic [SW-1:0] in_side,
  output logic               out_valid,
  output logic      [RW-1:0] out_den,
  output logic      [RW-1:0] out_rx,
  output logic      [RW-1:0] out_ry,
  output logic      [QW-1:0] out_qx,
  output logic      [QW-1:0] out_qy,
  output logic      [SW-1:0] out_side
);
  logic [RW-1:0] shx;
  logic [RW-1:0] shy;
  logic          gx;
  logic          gy;

  always_comb begin
    shx = FIRST ? in_rx : (in_rx << 1);
    shy = FIRST ? in_ry : (in_ry << 1);
    gx  = (shx >= in_den);
    gy  = (shy >= in_den);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_den  <= in_den;
      out_rx   <= gx ? (shx - in_den) : shx;
      out_ry   <= gy ? (shy - in_den) : shy;
      out_qx   <= {in_qx[QW-2:0], gx};
      out_qy   <= {in_qy[QW-2:0], gy};
      out_side <= in_side;
    end
  end
endmodule
`default_nettype wire

### bench/tb_top.sv
// Testbench for the stick radial deadzone block: directed table plus random samples.
`timescale 1ns / 100ps
module tb_top;
  import sdz_pkg::*;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
  } sample_t;

  typedef struct packed {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic               dz;
  } norm_t;

  typedef struct {
    sample_t s;
    bit      known;
    norm_t   r;
  } row_t;

  localparam int FULL = 32767;
  localparam int LAT  = 36;
  localparam int LIMIT = 400000;
  localparam int N_RAND = 850;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wen = 1'b0;
  logic [DZ_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [IN_W-1:0] stick_x = '0;
  logic signed [IN_W-1:0] stick_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [OUT_W-1:0] norm_x, norm_y;
  logic in_deadzone;

  norm_t expected_q[$];
  int unsigned radius;
  int errors = 0;
  int cycles = 0;
  bit hold_long = 1'b0;

  stick_radial_deadzone u_top (
    .clk(clk), .rst(rst), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .stick_x(stick_x), .stick_y(stick_y),
    .out_valid(out_valid), .out_stall(out_stall), .norm_x(norm_x), .norm_y(norm_y),
    .in_deadzone(in_deadzone)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint isqrt(longint n);
    longint r;
    r = 0;
    for (int b = 15; b >= 0; b--) begin
      if ((r + (64'd1 << b)) * (r + (64'd1 << b)) <= n) r = r + (64'd1 << b);
    end
    return r;
  endfunction

  function automatic logic signed [15:0] scale_axis(longint a, longint over, longint den);
    longint mag, q;
    mag = (a < 0) ? -a : a;
    q = ((mag * over) << 15) / den;
    if (q > FULL) q = FULL;
    return (a < 0) ? 16'(-q) : 16'(q);
  endfunction

  function automatic norm_t deadzone_norm(sample_t s, int unsigned dzr);
    longint x, y, r, m, dz, den;
    norm_t o;
    x = s.x;
    y = s.y;
    if (x < -FULL) x = -FULL;
    if (y < -FULL) y = -FULL;
    dz = (dzr > FULL - 1) ? FULL - 1 : dzr;
    r = isqrt(x * x + y * y);
    if (r <= dz) begin
      o = '{nx: 16'sd0, ny: 16'sd0, dz: 1'b1};
      return o;
    end
    m = (r > FULL) ? FULL : r;
    den = r * (FULL - dz);
    o.nx = scale_axis(x, m - dz, den);
    o.ny = scale_axis(y, m - dz, den);
    o.dz = 1'b0;
    return o;
  endfunction

  task automatic write_radius(int unsigned v);
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= DZ_W'(v);
    @(posedge clk);
    cfg_wen <= 1'b0;
    radius = (v > DZ_MAX) ? DZ_MAX : v;
  endtask

  task automatic send(sample_t s, bit known, norm_t r);
    @(posedge clk);
    in_valid <= 1'b1;
    stick_x <= s.x;
    stick_y <= s.y;
    expected_q.push_back(known ? r : deadzone_norm(s, radius));
    do @(posedge clk); while (in_stall);
    in_valid <= 1'b0;
  endtask

  task automatic send_burst(int n);
    sample_t s;
    int k;
    k = 0;
    while (k < n) begin
      @(posedge clk);
      if ($urandom_range(3) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(4)) @(posedge clk);
        @(posedge clk);
      end
      case ($urandom_range(3))
        0: s = '{x: 16'($urandom_range(8000) - 4000), y: 16'($urandom_range(8000) - 4000)};
        1: s = '{x: $urandom_range(1) ? 16'sh8000 : 16'sh7fff, y: 16'($urandom)};
        default: s = '{x: 16'($urandom), y: 16'($urandom)};
      endcase
      in_valid <= 1'b1;
      stick_x <= s.x;
      stick_y <= s.y;
      expected_q.push_back(deadzone_norm(s, radius));
      do @(posedge clk); while (in_stall);
      k++;
      for (int b = $urandom_range(6); b > 0 && k < n; b--) begin
        case ($urandom_range(1))
          0: s = '{x: 16'($urandom_range(8000) - 4000), y: 16'($urandom)};
          default: s = '{x: 16'($urandom), y: 16'($urandom)};
        endcase
        in_valid <= 1'b1;
        stick_x <= s.x;
        stick_y <= s.y;
        expected_q.push_back(deadzone_norm(s, radius));
        do @(posedge clk); while (in_stall);
        k++;
      end
      in_valid <= 1'b0;
    end
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LAT + 4) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (hold_long) out_stall <= 1'b1;
    else if (cycles % 97 < 20) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(3) == 0);
  end

  always @(posedge clk) begin
    norm_t e;
    cycles <= cycles + 1;
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("result with no request pending");
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (norm_x !== e.nx) begin
          $error("norm_x expected %0d actual %0d", e.nx, norm_x);
          errors++;
        end
        if (norm_y !== e.ny) begin
          $error("norm_y expected %0d actual %0d", e.ny, norm_y);
          errors++;
        end
        if (in_deadzone !== e.dz) begin
          $error("in_deadzone expected %0d actual %0d", e.dz, in_deadzone);
          errors++;
        end
      end
    end
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  row_t rows[$];

  initial begin
    norm_t zr, px, nx;
    zr = '{nx: 16'sd0, ny: 16'sd0, dz: 1'b1};
    px = '{nx: 16'sh7fff, ny: 16'sd0, dz: 1'b0};
    nx = '{nx: -16'sh7fff, ny: 16'sd0, dz: 1'b0};
    rows.push_back('{'{x: 16'sd0, y: 16'sd0}, 1'b1, zr});
    rows.push_back('{'{x: 16'sh7fff, y: 16'sd0}, 1'b1, px});
    rows.push_back('{'{x: 16'sh8000, y: 16'sd0}, 1'b1, nx});
    rows.push_back('{'{x: 16'sd3924, y: 16'sd0}, 1'b1, zr});
    rows.push_back('{'{x: 16'sd3925, y: 16'sd0}, 1'b0, zr});
    rows.push_back('{'{x: 16'sh8000, y: 16'sh8000}, 1'b0, zr});
    rows.push_back('{'{x: 16'sh7fff, y: 16'sh7fff}, 1'b0, zr});
    rows.push_back('{'{x: 16'sd0, y: -16'sd20000}, 1'b0, zr});
    rows.push_back('{'{x: 16'sd3000, y: -16'sd3000}, 1'b0, zr});
    rows.push_back('{'{x: -16'sd1, y: 16'sh7fff}, 1'b0, zr});
    radius = DZ_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    foreach (rows[i]) send(rows[i].s, rows[i].known, rows[i].r);
    drain();
    write_radius(0);
    send('{x: 16'sd1, y: 16'sd0}, 1'b0, zr);
    send('{x: 16'sd0, y: 16'sd0}, 1'b1, zr);
    send('{x: 16'sh8000, y: 16'sh7fff}, 1'b0, zr);
    drain();
    write_radius(32767);
    send('{x: 16'sh7fff, y: 16'sd0}, 1'b1, px);
    send('{x: 16'sh7fff, y: 16'sh7fff}, 1'b0, zr);
    send('{x: 16'sh8000, y: 16'sh8000}, 1'b0, zr);
    drain();
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: write_radius(DZ_RESET);
        1: write_radius(32766);
        2: write_radius(0);
        default: write_radius($urandom_range(32767));
      endcase
      if (p == 2) begin
        hold_long <= 1'b1;
        fork
          begin
            repeat (200) @(posedge clk);
            hold_long <= 1'b0;
          end
          send_burst(N_RAND / 5);
        join
      end else begin
        send_burst(N_RAND / 5);
      end
      drain();
    end
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
